// ===== design/cis_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cone isolation sum package
// Shared widths, codes, word layouts and the controller/datapath interface.
// ----------------------------------------------------------------------------
package cis_pkg;

    localparam int PT_W       = 16;
    localparam int ETA_W      = 13;
    localparam int PHI_W      = 12;
    localparam int ID_W       = 16;
    localparam int EDGE_W     = 12;
    localparam int SUM_W      = 24;
    localparam int RATIO_W    = 20;
    localparam int NUM_W      = 35;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int S_TDATA_W  = 88;
    localparam int S_TUSER_W  = 2;
    localparam int M_TDATA_W  = 144;
    localparam int OBJ_W      = 59;
    localparam int RHO_W      = 40;

    localparam logic [SUM_W-1:0]   SUM_SAT   = '1;
    localparam logic [RATIO_W-1:0] RATIO_SAT = '1;

    localparam logic [CFG_IDX_W-1:0] CFG_DR_MAX_SQ    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DR_MIN_SQ    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PT_MIN       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PT_SUM_MAX   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PT_RATIO_MAX = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RHO_AREA     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE_FLAGS   = 3'd6;

    localparam int MODE_SUM_CUT = 0;
    localparam int MODE_RHO     = 1;
    localparam int MODE_MINI    = 2;

    typedef enum logic [1:0] {
        OP_CLEAR    = 2'd0,
        OP_LOAD_OBJ = 2'd1,
        OP_LOAD_RHO = 2'd2,
        OP_EVAL     = 2'd3
    } op_t;

    typedef struct packed {
        logic [23:0] dr_max_sq;
        logic [23:0] dr_min_sq;
        logic [15:0] pt_min;
        logic [23:0] pt_sum_max;
        logic [19:0] pt_ratio_max;
        logic [15:0] rho_area;
        logic [2:0]  mode_flags;
    } cfg_t;

    // Input word layout, last field in the lowest bits.
    typedef struct packed {
        logic [EDGE_W-1:0]       edge_high;
        logic [EDGE_W-1:0]       edge_low;
        logic [ID_W-1:0]         object_id;
        logic                    pileup;
        logic                    charged;
        logic [PHI_W-1:0]        phi;
        logic signed [ETA_W-1:0] eta;
        logic [PT_W-1:0]         pt;
    } in_item_t;

    typedef struct packed {
        logic [ID_W-1:0]         id;
        logic                    pileup;
        logic                    charged;
        logic [PHI_W-1:0]        phi;
        logic signed [ETA_W-1:0] eta;
        logic [PT_W-1:0]         pt;
    } obj_t;

    typedef struct packed {
        logic [EDGE_W-1:0] hi;
        logic [EDGE_W-1:0] lo;
        logic [PT_W-1:0]   rho;
    } rho_t;

    typedef struct packed {
        logic clear;
        logic load_obj;
        logic load_rho;
        logic rho_start;
        logic obj_start;
        logic corr_mul;
        logic corr_sum;
        logic pass_eval;
        logic div_start;
        logic div_sel_rc;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic rho_done;
        logic obj_done;
        logic div_done;
        logic out_busy;
    } status_t;

    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                                 input logic [PT_W-1:0] b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + {{(SUM_W+1-PT_W){1'b0}}, b};
        return s[SUM_W] ? SUM_SAT : s[SUM_W-1:0];
    endfunction

endpackage

// ===== design/cis_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cone isolation sum RAM
// Generic single write port, single read port memory with registered read.
// ----------------------------------------------------------------------------
module cis_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/cis_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cone isolation sum divider
// Restoring divider, one quotient bit per cycle, saturating at the ratio limit.
// ----------------------------------------------------------------------------
module cis_div (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [cis_pkg::NUM_W-1:0]    num,
    input  logic [cis_pkg::PT_W-1:0]     den,
    output logic                         done,
    output logic [cis_pkg::RATIO_W-1:0]  quo
);
    import cis_pkg::*;

    localparam int REM_W = NUM_W + 1;
    localparam int K_W   = $clog2(RATIO_W);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [REM_W-1:0]    rem_reg, rem_next;
    logic [RATIO_W-1:0]  quo_reg, quo_next;
    logic [K_W-1:0]      k_reg, k_next;
    logic [REM_W-1:0]    shifted;
    logic [REM_W-1:0]    den_top;

    assign shifted = {{(REM_W-PT_W){1'b0}}, den} << k_reg;
    assign den_top = {den, {RATIO_W{1'b0}}};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        k_next    = k_reg;
        if (start) begin
            if ({1'b0, num} >= den_top) begin
                quo_next  = RATIO_SAT;
                done_next = 1'b1;
                busy_next = 1'b0;
            end else begin
                rem_next  = {1'b0, num};
                quo_next  = '0;
                k_next    = K_W'(RATIO_W - 1);
                busy_next = 1'b1;
            end
        end else if (busy_reg) begin
            if (rem_reg >= shifted) begin
                rem_next = rem_reg - shifted;
                quo_next = quo_reg | (RATIO_W'(1) << k_reg);
            end
            if (k_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                k_next = k_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        k_reg   <= k_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

// ===== design/cis_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cone isolation sum datapath
// Object and rho tables, cone scan pipeline, corrections, ratios and output.
// ----------------------------------------------------------------------------
module cis_dp #(
    parameter int MAX_OBJECTS  = 256,
    parameter int MAX_RHO_BINS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_accept,
    input  cis_pkg::in_item_t             in_item,
    input  cis_pkg::cfg_t                 cfg,
    input  cis_pkg::cmd_t                 cmd,
    input  logic                          m_tready,
    output cis_pkg::status_t              status,
    output logic                          m_tvalid,
    output logic [cis_pkg::M_TDATA_W-1:0] m_tdata
);
    import cis_pkg::*;

    localparam int OAW = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;
    localparam int OCW = $clog2(MAX_OBJECTS + 1);
    localparam int RAW = (MAX_RHO_BINS > 1) ? $clog2(MAX_RHO_BINS) : 1;
    localparam int RCW = $clog2(MAX_RHO_BINS + 1);
    localparam int PAD_W = M_TDATA_W - (1 + 4 * SUM_W + 2 * RATIO_W);

    in_item_t            item_reg;
    logic [OCW-1:0]      obj_count_reg;
    logic [RCW-1:0]      rho_count_reg;

    obj_t                obj_wdata, obj_rdata;
    rho_t                rho_wdata, rho_rdata;
    logic                obj_we, rho_we;

    logic                rho_run_reg, rv_reg;
    logic [RCW-1:0]      ridx_reg;
    logic [PT_W-1:0]     rho_val_reg;
    logic [ETA_W-1:0]    abs_eta;

    logic                orun_reg, v1_reg, v2_reg, v3_reg, v4_reg;
    logic [OCW-1:0]      oidx_reg;
    logic signed [13:0]  de_next, de_reg;
    logic [PHI_W-1:0]    dp_raw, dp_next, dp_reg;
    logic [PT_W-1:0]     pt2_reg, pt3_reg, pt4_reg;
    logic                ch2_reg, ch3_reg, ch4_reg;
    logic                pu2_reg, pu3_reg, pu4_reg;
    logic                idne2_reg, idne3_reg;
    logic [27:0]         sqe_reg;
    logic [23:0]         sqp_reg;
    logic [27:0]         dr2;
    logic                hit_next, hit4_reg;

    logic [SUM_W-1:0]    s_ch_reg, s_pu_reg, s_ne_reg, s_all_reg;

    logic [31:0]         corr_reg;
    logic [35:0]         lim_reg;
    logic [SUM_W:0]      nh;
    logic [25:0]         db_half_reg;
    logic [33:0]         nk;
    logic [NUM_W-1:0]    rc_k_reg;
    logic [NUM_W-1:0]    db_sc;
    logic [NUM_W-1:0]    sum_sel;
    logic                pass_reg;

    logic                div_done;
    logic [RATIO_W-1:0]  div_quo;
    logic                div_sel_reg;
    logic [RATIO_W-1:0]  r_db_reg, r_rc_reg;

    logic                m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    // Table writes.
    assign obj_we = cmd.load_obj && (item_reg.pt >= cfg.pt_min)
                    && (obj_count_reg != OCW'(MAX_OBJECTS));
    assign rho_we = cmd.load_rho && (rho_count_reg != RCW'(MAX_RHO_BINS));

    assign obj_wdata = '{id: item_reg.object_id, pileup: item_reg.pileup,
                         charged: item_reg.charged, phi: item_reg.phi,
                         eta: item_reg.eta, pt: item_reg.pt};
    assign rho_wdata = '{hi: item_reg.edge_high, lo: item_reg.edge_low,
                         rho: item_reg.pt};

    cis_ram #(.WIDTH(OBJ_W), .DEPTH(MAX_OBJECTS)) u_obj_ram (
        .aclk    (aclk),
        .wr_en   (obj_we),
        .wr_addr (obj_count_reg[OAW-1:0]),
        .wr_data (obj_wdata),
        .rd_addr (oidx_reg[OAW-1:0]),
        .rd_data (obj_rdata)
    );

    cis_ram #(.WIDTH(RHO_W), .DEPTH(MAX_RHO_BINS)) u_rho_ram (
        .aclk    (aclk),
        .wr_en   (rho_we),
        .wr_addr (rho_count_reg[RAW-1:0]),
        .wr_data (rho_wdata),
        .rd_addr (ridx_reg[RAW-1:0]),
        .rd_data (rho_rdata)
    );

    assign abs_eta = item_reg.eta[ETA_W-1] ? (~item_reg.eta + 1'b1) : item_reg.eta;

    // Cone geometry of the object read back from the table.
    assign de_next = 14'(item_reg.eta) - 14'(obj_rdata.eta);
    assign dp_raw  = item_reg.phi - obj_rdata.phi;
    assign dp_next = (dp_raw > 12'd2048) ? 12'(13'd4096 - {1'b0, dp_raw}) : dp_raw;
    assign dr2     = sqe_reg + {4'b0, sqp_reg};

    always_comb begin
        hit_next = dr2 <= {4'b0, cfg.dr_max_sq};
        if (cfg.mode_flags[MODE_MINI]) begin
            hit_next = hit_next && (dr2 > {4'b0, cfg.dr_min_sq});
        end else begin
            hit_next = hit_next && idne3_reg;
        end
    end

    assign nh    = {s_ne_reg, 1'b0};
    assign nk    = {s_ne_reg, 10'b0};
    assign db_sc = {db_half_reg, 9'b0};
    assign sum_sel = cfg.mode_flags[MODE_RHO] ? rc_k_reg : db_sc;

    cis_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .num     (cmd.div_sel_rc ? rc_k_reg : db_sc),
        .den     (item_reg.pt),
        .done    (div_done),
        .quo     (div_quo)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            obj_count_reg <= '0;
            rho_count_reg <= '0;
            rho_run_reg   <= 1'b0;
            rv_reg        <= 1'b0;
            orun_reg      <= 1'b0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            if (cmd.clear) begin
                obj_count_reg <= '0;
                rho_count_reg <= '0;
            end
            if (obj_we) begin
                obj_count_reg <= obj_count_reg + 1'b1;
            end
            if (rho_we) begin
                rho_count_reg <= rho_count_reg + 1'b1;
            end

            if (cmd.rho_start) begin
                rho_run_reg <= 1'b1;
                rv_reg      <= 1'b0;
            end else begin
                rv_reg <= rho_run_reg && (ridx_reg != rho_count_reg);
                if (rho_run_reg && (ridx_reg == rho_count_reg)) begin
                    rho_run_reg <= 1'b0;
                end
            end

            if (cmd.obj_start) begin
                orun_reg <= 1'b1;
                v1_reg   <= 1'b0;
            end else begin
                v1_reg <= orun_reg && (oidx_reg != obj_count_reg);
                if (orun_reg && (oidx_reg == obj_count_reg)) begin
                    orun_reg <= 1'b0;
                end
            end
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;

            if (cmd.out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            item_reg <= in_item;
        end

        if (cmd.rho_start) begin
            ridx_reg    <= '0;
            rho_val_reg <= '0;
        end else begin
            if (rho_run_reg && (ridx_reg != rho_count_reg)) begin
                ridx_reg <= ridx_reg + 1'b1;
            end
            if (rv_reg && (abs_eta >= {1'b0, rho_rdata.lo})
                    && (abs_eta < {1'b0, rho_rdata.hi})) begin
                rho_val_reg <= rho_rdata.rho;
            end
        end

        if (cmd.obj_start) begin
            oidx_reg  <= '0;
            s_ch_reg  <= '0;
            s_pu_reg  <= '0;
            s_ne_reg  <= '0;
            s_all_reg <= '0;
        end else begin
            if (orun_reg && (oidx_reg != obj_count_reg)) begin
                oidx_reg <= oidx_reg + 1'b1;
            end
            if (v4_reg && hit4_reg) begin
                s_all_reg <= sat_add(s_all_reg, pt4_reg);
                if (ch4_reg) begin
                    if (pu4_reg) begin
                        s_pu_reg <= sat_add(s_pu_reg, pt4_reg);
                    end else begin
                        s_ch_reg <= sat_add(s_ch_reg, pt4_reg);
                    end
                end else begin
                    s_ne_reg <= sat_add(s_ne_reg, pt4_reg);
                end
            end
        end

        de_reg    <= de_next;
        dp_reg    <= dp_next;
        pt2_reg   <= obj_rdata.pt;
        ch2_reg   <= obj_rdata.charged;
        pu2_reg   <= obj_rdata.pileup;
        idne2_reg <= obj_rdata.id != item_reg.object_id;

        sqe_reg   <= 28'(de_reg) * 28'(de_reg);
        sqp_reg   <= 24'(dp_reg) * 24'(dp_reg);
        pt3_reg   <= pt2_reg;
        ch3_reg   <= ch2_reg;
        pu3_reg   <= pu2_reg;
        idne3_reg <= idne2_reg;

        hit4_reg  <= hit_next;
        pt4_reg   <= pt3_reg;
        ch4_reg   <= ch3_reg;
        pu4_reg   <= pu3_reg;

        if (cmd.corr_mul) begin
            corr_reg    <= 32'(rho_val_reg) * 32'(cfg.rho_area);
            lim_reg     <= 36'(cfg.pt_ratio_max) * 36'(item_reg.pt);
            db_half_reg <= {1'b0, s_ch_reg, 1'b0}
                           + ((nh > {1'b0, s_pu_reg}) ? {1'b0, nh - {1'b0, s_pu_reg}} : 26'd0);
        end
        if (cmd.corr_sum) begin
            rc_k_reg <= {1'b0, s_ch_reg, 10'b0}
                        + ((nk > {2'b0, corr_reg}) ? {1'b0, nk - {2'b0, corr_reg}}
                                                    : 35'd0);
        end
        if (cmd.pass_eval) begin
            if (cfg.mode_flags[MODE_SUM_CUT]) begin
                pass_reg <= !(sum_sel > {1'b0, cfg.pt_sum_max, 10'b0});
            end else begin
                pass_reg <= !({1'b0, sum_sel} > lim_reg);
            end
        end

        if (cmd.div_start) begin
            div_sel_reg <= cmd.div_sel_rc;
        end
        if (div_done) begin
            if (div_sel_reg) begin
                r_rc_reg <= div_quo;
            end else begin
                r_db_reg <= div_quo;
            end
        end

        if (cmd.out_load) begin
            m_tdata_reg <= {{PAD_W{1'b0}}, r_rc_reg, r_db_reg, s_all_reg, s_ne_reg,
                            s_pu_reg, s_ch_reg, pass_reg};
        end
    end

    assign status.rho_done = !rho_run_reg && !rv_reg;
    assign status.obj_done = !orun_reg && !v1_reg && !v2_reg && !v3_reg && !v4_reg;
    assign status.div_done = div_done;
    assign status.out_busy = m_tvalid_reg;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== design/cis_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cone isolation sum controller
// Sequences clears, table loads and the steps of one candidate evaluation.
// ----------------------------------------------------------------------------
module cis_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    input  cis_pkg::op_t      op,
    input  logic              m_tready,
    input  cis_pkg::status_t  status,
    output logic              s_tready,
    output cis_pkg::cmd_t     cmd
);
    import cis_pkg::*;

    typedef enum logic [3:0] {
        IDLE,
        RHO_START,
        RHO_SCAN,
        OBJ_START,
        OBJ_SCAN,
        CORR_MUL,
        CORR_SUM,
        DB_START,
        DB_WAIT,
        RC_START,
        RC_WAIT,
        OUT
    } state_t;

    state_t state_reg, state_next;
    cmd_t   cmd_reg, cmd_next;
    logic   ready_reg, ready_next;

    always_comb begin
        state_next = state_reg;
        cmd_next   = '0;
        case (state_reg)
            IDLE: begin
                if (s_tvalid) begin
                    case (op)
                        OP_CLEAR:    cmd_next.clear = 1'b1;
                        OP_LOAD_OBJ: cmd_next.load_obj = 1'b1;
                        OP_LOAD_RHO: cmd_next.load_rho = 1'b1;
                        OP_EVAL: begin
                            cmd_next.rho_start = 1'b1;
                            state_next = RHO_START;
                        end
                        default: state_next = IDLE;
                    endcase
                end
            end
            RHO_START: state_next = RHO_SCAN;
            RHO_SCAN: begin
                if (status.rho_done) begin
                    cmd_next.obj_start = 1'b1;
                    state_next = OBJ_START;
                end
            end
            OBJ_START: state_next = OBJ_SCAN;
            OBJ_SCAN: begin
                if (status.obj_done) begin
                    cmd_next.corr_mul = 1'b1;
                    state_next = CORR_MUL;
                end
            end
            CORR_MUL: begin
                cmd_next.corr_sum = 1'b1;
                state_next = CORR_SUM;
            end
            CORR_SUM: begin
                cmd_next.div_start = 1'b1;
                cmd_next.pass_eval = 1'b1;
                state_next = DB_START;
            end
            DB_START: state_next = DB_WAIT;
            DB_WAIT: begin
                if (status.div_done) begin
                    cmd_next.div_start  = 1'b1;
                    cmd_next.div_sel_rc = 1'b1;
                    state_next = RC_START;
                end
            end
            RC_START: state_next = RC_WAIT;
            RC_WAIT: begin
                if (status.div_done) begin
                    state_next = OUT;
                end
            end
            OUT: begin
                if (!status.out_busy || m_tready) begin
                    cmd_next.out_load = 1'b1;
                    state_next = IDLE;
                end
            end
            default: state_next = IDLE;
        endcase
        ready_next = (state_next == IDLE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= IDLE;
            cmd_reg   <= '0;
            ready_reg <= 1'b1;
        end else begin
            state_reg <= state_next;
            cmd_reg   <= cmd_next;
            ready_reg <= ready_next;
        end
    end

    assign s_tready = ready_reg;
    assign cmd      = cmd_reg;

endmodule

// ===== design/cone_isolation_sum_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cone isolation sum unit
// Pile-up corrected cone isolation of candidates against one event's objects.
// ----------------------------------------------------------------------------
// A new clear or load word is accepted every cycle while no evaluation is in progress.
// An evaluate word reads both tables one entry per cycle and computes each ratio on a shared
// divider, which returns the ratio limit without iterating when the quotient would saturate.
// A result left waiting stalls the next one.
// Reset clears the object and rho counts and loads the register reset values.
// The tables themselves are not cleared; they are read only below their counts.
module cone_isolation_sum_unit #(
    parameter int MAX_OBJECTS  = 256,
    parameter int MAX_RHO_BINS = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // pt, eta, phi, charged, pileup, object_id, edge_low, edge_high
    input  logic [cis_pkg::S_TDATA_W-1:0]    s_tdata,
    // operation
    input  logic [cis_pkg::S_TUSER_W-1:0]    s_tuser,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // pass, sum_charged, sum_charged_pileup, sum_neutral, sum_all,
    // ratio_delta_beta, ratio_rho_corrected
    output logic [cis_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic                             cfg_wr_en,
    input  logic [cis_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [cis_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
    import cis_pkg::*;

    cfg_t     cfg_reg, cfg_next;
    cmd_t     cmd;
    status_t  status;
    in_item_t in_item;
    op_t      op;

    assign in_item = in_item_t'(s_tdata[$bits(in_item_t)-1:0]);
    assign op      = op_t'(s_tuser);

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                CFG_DR_MAX_SQ:    cfg_next.dr_max_sq    = cfg_wdata;
                CFG_DR_MIN_SQ:    cfg_next.dr_min_sq    = cfg_wdata;
                CFG_PT_MIN:       cfg_next.pt_min       = cfg_wdata[15:0];
                CFG_PT_SUM_MAX:   cfg_next.pt_sum_max   = cfg_wdata;
                CFG_PT_RATIO_MAX: cfg_next.pt_ratio_max = cfg_wdata[19:0];
                CFG_RHO_AREA:     cfg_next.rho_area     = cfg_wdata[15:0];
                CFG_MODE_FLAGS:   cfg_next.mode_flags   = cfg_wdata[2:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.dr_max_sq    <= 24'd106276;
            cfg_reg.dr_min_sq    <= 24'd42;
            cfg_reg.pt_min       <= 16'd2;
            cfg_reg.pt_sum_max   <= 24'd20;
            cfg_reg.pt_ratio_max <= 20'd102;
            cfg_reg.rho_area     <= 16'd804;
            cfg_reg.mode_flags   <= 3'd2;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    cis_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .op       (op),
        .m_tready (m_tready),
        .status   (status),
        .s_tready (s_tready),
        .cmd      (cmd)
    );

    cis_dp #(
        .MAX_OBJECTS  (MAX_OBJECTS),
        .MAX_RHO_BINS (MAX_RHO_BINS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (s_tvalid && s_tready),
        .in_item   (in_item),
        .cfg       (cfg_reg),
        .cmd       (cmd),
        .m_tready  (m_tready),
        .status    (status),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata)
    );

endmodule
